// ===== rtl/mfa_pkg.sv =====
// Package for the Montgomery field ALU: field constants, opcodes, pipeline types.
// No dependencies.
package mfa_pkg;

    localparam int unsigned LimbW    = 64;
    localparam int unsigned HalfW    = LimbW / 2;
    localparam int unsigned NumLimbs = 4;
    localparam int unsigned NumRounds = 4;

    typedef logic [LimbW-1:0] limb_t;
    typedef limb_t [NumLimbs-1:0] num_t;
    typedef logic [2*LimbW-1:0] prod_t;
    // Four 32x32 partial products of one limb product: ll, lh, hl, hh.
    typedef limb_t [3:0] pp_t;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_SUB      = 2'd1,
        OP_MUL      = 2'd2,
        OP_FROM_MONT = 2'd3
    } op_t;

    // -q^-1 mod 2^64 is 2^64 - 2^32 - 1; the rounds form m from it by shift and subtract.
    localparam num_t  QMod = {64'd8353516859464449352, 64'd3691218898639771653,
                              64'd6034159408538082302, 64'd18446744069414584321};

    // Working set carried between pipeline stages.
    typedef struct packed {
        op_t  op;
        logic borrow;
        num_t a;
        num_t b;
        num_t t;
    } stage_t;

    // Split a limb product into 32x32 partial products.
    function automatic pp_t mul_parts(input limb_t x, input limb_t y);
        logic [HalfW-1:0] xl, xh, yl, yh;
        xl = x[HalfW-1:0];
        xh = x[LimbW-1:HalfW];
        yl = y[HalfW-1:0];
        yh = y[LimbW-1:HalfW];
        mul_parts[0] = {{HalfW{1'b0}}, xl} * {{HalfW{1'b0}}, yl};
        mul_parts[1] = {{HalfW{1'b0}}, xl} * {{HalfW{1'b0}}, yh};
        mul_parts[2] = {{HalfW{1'b0}}, xh} * {{HalfW{1'b0}}, yl};
        mul_parts[3] = {{HalfW{1'b0}}, xh} * {{HalfW{1'b0}}, yh};
    endfunction

    // Combine partial products into the exact 128-bit product.
    function automatic prod_t mul_join(input pp_t pp);
        mul_join = {pp[3], pp[0]}
                 + {{HalfW{1'b0}}, pp[1], {HalfW{1'b0}}}
                 + {{HalfW{1'b0}}, pp[2], {HalfW{1'b0}}};
    endfunction

    // Conditional subtraction of q when v >= q.
    function automatic num_t reduce_once(input num_t v);
        logic [NumLimbs*LimbW:0] d;
        d = {1'b0, v} - {1'b0, QMod};
        reduce_once = d[NumLimbs*LimbW] ? v : num_t'(d[NumLimbs*LimbW-1:0]);
    endfunction

endpackage

// ===== rtl/montgomery_field_alu_top.sv =====
// Montgomery field ALU over the BLS12-381 scalar modulus: top level.
// Depends on mfa_pkg and mfa_round.
//
// Usage: present an operation on req_type with two 256-bit operands as four
// 64-bit limbs each (w0 least significant) under in_valid/in_ready. Each
// transfer yields one reduced 256-bit result under out_valid/out_ready.
// Ops: add, subtract, Montgomery multiply, conversion out of Montgomery form.
// Every operation takes the same path: the entry stage loads on the transfer edge,
// then four CIOS rounds of six stages each and one final stage, whose register
// drives out_valid. Throughput: one item per cycle while the output is not stalled;
// each round stage holds one bank of 32x32 partial products, one product join
// or one add row, and the pipe advances as a whole.
// All operations share the pipe, so results leave in order.
// Reset clears all valid bits; the pipe starts empty.
// When the receiver stalls, the whole pipe holds; in_ready is high whenever
// the output register is empty or being taken, so items keep flowing while
// a finished result is taken in the same cycle.
module montgomery_field_alu_top
    import mfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [63:0] operand_a_w0,
    input  logic [63:0] operand_a_w1,
    input  logic [63:0] operand_a_w2,
    input  logic [63:0] operand_a_w3,
    input  logic [63:0] operand_b_w0,
    input  logic [63:0] operand_b_w1,
    input  logic [63:0] operand_b_w2,
    input  logic [63:0] operand_b_w3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_w0,
    output logic [63:0] result_w1,
    output logic [63:0] result_w2,
    output logic [63:0] result_w3
);

    logic adv;
    logic out_valid_reg;
    num_t res_reg, res_next;

    // Advance when the output register is free or drains this cycle.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Entry stage: add/sub raw sums here; multiply gets t cleared, from-Montgomery gets t = a, b cleared.
    stage_t s0_next, s0_reg;
    logic   v0_reg;

    always_comb
    begin
        logic [NumLimbs*LimbW:0] r;
        num_t a, b;
        a = {operand_a_w3, operand_a_w2, operand_a_w1, operand_a_w0};
        b = {operand_b_w3, operand_b_w2, operand_b_w1, operand_b_w0};
        s0_next.op     = op_t'(req_type);
        s0_next.borrow = 1'b0;
        s0_next.a      = a;
        s0_next.b      = b;
        s0_next.t      = '0;
        case (op_t'(req_type))
            OP_ADD:
            begin
                r = {1'b0, a} + {1'b0, b};
                s0_next.t = num_t'(r[NumLimbs*LimbW-1:0]);
            end
            OP_SUB:
            begin
                r = {1'b0, a} - {1'b0, b};
                s0_next.t      = num_t'(r[NumLimbs*LimbW-1:0]);
                s0_next.borrow = r[NumLimbs*LimbW];
            end
            OP_FROM_MONT:
            begin
                r = '0;
                s0_next.t = a;
                s0_next.b = '0;
            end
            default:
                r = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s0_reg <= s0_next;
    end

    // Round chain; add/sub pass through untouched.
    stage_t rd_data [NumRounds+1];
    logic   rd_valid [NumRounds+1];
    assign rd_data[0]  = s0_reg;
    assign rd_valid[0] = v0_reg;

    for (genvar i = 0; i < NumRounds; i++)
    begin : g_round
        limb_t  xi;
        // Multiply takes limb i of a; from-Montgomery runs with x_i = 0.
        assign xi = (rd_data[i].op == OP_MUL) ? rd_data[i].a[i] : '0;
        mfa_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (rd_valid[i]),
            .in_data   (rd_data[i]),
            .xi        (xi),
            .out_valid (rd_valid[i+1]),
            .out_data  (rd_data[i+1])
        );
    end

    // Final stage: a subtract adds q back on a borrow; other ops get a conditional subtraction of q.
    always_comb
    begin
        case (rd_data[NumRounds].op)
            OP_SUB:
                res_next = rd_data[NumRounds].borrow
                         ? num_t'(rd_data[NumRounds].t + QMod)
                         : rd_data[NumRounds].t;
            default:
                res_next = reduce_once(rd_data[NumRounds].t);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= rd_valid[NumRounds];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign result_w0 = res_reg[0];
    assign result_w1 = res_reg[1];
    assign result_w2 = res_reg[2];
    assign result_w3 = res_reg[3];

endmodule

// ===== rtl/mfa_round.sv =====
// One CIOS round of the Montgomery multiply, split over six register stages.
// Depends on mfa_pkg. Handles both multiply and from-Montgomery rounds.
module mfa_round
    import mfa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  stage_t in_data,
    input  limb_t  xi,
    output logic   out_valid,
    output stage_t out_data
);

    // Stage 1: x_i * y partial products (from-Montgomery has x_i = 0 and t = a).
    pp_t [NumLimbs-1:0] xyp_next, xyp_reg;
    stage_t s1_reg;
    logic   v1_reg;

    always_comb
    begin
        for (int j = 0; j < NumLimbs; j++)
            xyp_next[j] = mul_parts(xi, in_data.b[j]);
    end

    // Stage 2: join partial products into x_i * y limbs.
    prod_t [NumLimbs-1:0] xy_next, xy_reg;
    stage_t s2_reg;
    logic   v2_reg;

    always_comb
    begin
        for (int j = 0; j < NumLimbs; j++)
            xy_next[j] = mul_join(xyp_reg[j]);
    end

    // Stage 3: accumulate x_i*y + t and form m = -(acc0 * (2^32 + 1)) mod 2^64 from its new low limb.
    num_t   acc_next, acc_reg;
    limb_t  c1_next, c1_reg;
    limb_t  m_next, m_reg;
    stage_t s3_reg;
    logic   v3_reg;

    always_comb
    begin
        prod_t s;
        limb_t c;
        c = '0;
        for (int j = 0; j < NumLimbs; j++)
        begin
            s = xy_reg[j] + {{LimbW{1'b0}}, s2_reg.t[j]} + {{LimbW{1'b0}}, c};
            acc_next[j] = s[LimbW-1:0];
            c = s[2*LimbW-1:LimbW];
        end
        c1_next = c;
        m_next  = '0 - acc_next[0] - {acc_next[0][HalfW-1:0], {HalfW{1'b0}}};
    end

    // Stage 4: m * q partial products.
    pp_t [NumLimbs-1:0] mqp_next, mqp_reg;
    num_t   acc4_reg;
    limb_t  c14_reg;
    stage_t s4_reg;
    logic   v4_reg;

    always_comb
    begin
        for (int j = 0; j < NumLimbs; j++)
            mqp_next[j] = mul_parts(m_reg, QMod[j]);
    end

    // Stage 5: join partial products into m * q limbs.
    prod_t [NumLimbs-1:0] mq_next, mq_reg;
    num_t   acc5_reg;
    limb_t  c15_reg;
    stage_t s5_reg;
    logic   v5_reg;

    always_comb
    begin
        for (int j = 0; j < NumLimbs; j++)
            mq_next[j] = mul_join(mqp_reg[j]);
    end

    // Stage 6: add m*q, shift down one limb; top word wraps modulo 2^64.
    // Add and subtract items pass with their t untouched.
    stage_t out_next;
    always_comb
    begin
        prod_t s;
        limb_t c;
        num_t  t;
        out_next = s5_reg;
        s = mq_reg[0] + {{LimbW{1'b0}}, acc5_reg[0]};
        c = s[2*LimbW-1:LimbW];
        for (int j = 1; j < NumLimbs; j++)
        begin
            s = mq_reg[j] + {{LimbW{1'b0}}, acc5_reg[j]} + {{LimbW{1'b0}}, c};
            t[j-1] = s[LimbW-1:0];
            c = s[2*LimbW-1:LimbW];
        end
        t[NumLimbs-1] = c + c15_reg;
        if (s5_reg.op == OP_MUL || s5_reg.op == OP_FROM_MONT)
            out_next.t = t;
    end

    // Advance valid bits on every enabled cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            out_valid <= v5_reg;
        end
    end

    // Advance payload alongside.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xyp_reg  <= xyp_next;
            s1_reg   <= in_data;
            xy_reg   <= xy_next;
            s2_reg   <= s1_reg;
            acc_reg  <= acc_next;
            c1_reg   <= c1_next;
            m_reg    <= m_next;
            s3_reg   <= s2_reg;
            mqp_reg  <= mqp_next;
            acc4_reg <= acc_reg;
            c14_reg  <= c1_reg;
            s4_reg   <= s3_reg;
            mq_reg   <= mq_next;
            acc5_reg <= acc4_reg;
            c15_reg  <= c14_reg;
            s5_reg   <= s4_reg;
            out_data <= out_next;
        end
    end

endmodule

// ===== rtl/mfa_checker.sv =====
// Port-level checker for the Montgomery field ALU, bound to the top level.
// Depends on montgomery_field_alu_top ports only.
module mfa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] result_w0,
    input logic [63:0] result_w3
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_w0) && $stable(result_w3))
        else $error("stalled result changed");

    // Input is ready whenever the output is not stalled.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input blocked without output stall");

    // A stall on the output blocks the input.
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during stall");

    // Nothing comes out right after reset.
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("output valid after reset");

endmodule

bind montgomery_field_alu_top mfa_checker u_mfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_w0 (result_w0),
    .result_w3 (result_w3)
);
